FILE: hw/rtl/ucfc_pkg.sv
// Shared types and constants for the UART command frame checker.
package ucfc_pkg;

  localparam int unsigned FrameBytes = 9;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CountW     = 8;
  localparam int unsigned CountIdxW  = $clog2(FrameBytes);

  localparam logic [ByteW-1:0] HeaderReset = 8'h30;
  localparam logic [ByteW-1:0] TailReset   = 8'h36;

  localparam logic [ByteW-1:0] FuncDecimal = 8'hF5;
  localparam logic [ByteW-1:0] FuncE4      = 8'hE4;
  localparam logic [ByteW-1:0] FuncD3      = 8'hD3;
  localparam logic [ByteW-1:0] FuncC2      = 8'hC2;
  localparam logic [ByteW-1:0] FuncB1      = 8'hB1;
  localparam logic [ByteW-1:0] FuncA0      = 8'hA0;

  localparam logic [15:0] DecBias = 16'(48 * 1111);

  localparam logic CfgHeader = 1'b0;
  localparam logic CfgTail   = 1'b1;

  localparam logic ReqByte    = 1'b0;
  localparam logic ReqTimeout = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_FRAME = 2'd1,
    ST_BAD_SUM   = 2'd2,
    ST_BAD_FUNC  = 2'd3
  } status_e;

  typedef logic [FrameBytes-1:0][ByteW-1:0] frame_t;

  typedef struct packed {
    logic             req_type;
    logic [ByteW-1:0] rx_byte;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [ByteW-1:0]  function_code;
    logic [ByteW-1:0]  length_byte;
    logic [ByteW-1:0]  data_0;
    logic [ByteW-1:0]  data_1;
    logic [ByteW-1:0]  data_2;
    logic [ByteW-1:0]  data_3;
    logic [15:0]       decimal_value;
    logic [CountW-1:0] burst_length;
  } res_t;

  typedef struct packed {
    logic [ByteW-1:0] header_byte;
    logic [ByteW-1:0] tail_byte;
  } cfg_t;

  typedef struct packed {
    logic store_byte;
    logic close_burst;
  } store_ctrl_t;

endpackage

FILE: hw/rtl/ucfc_req_if.sv
// Request channel carrying received bytes and timeout events.
interface ucfc_req_if;
  logic          valid;
  logic          ready;
  ucfc_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/ucfc_res_if.sv
// Result channel carrying one frame report per closed burst.
interface ucfc_res_if;
  logic          valid;
  logic          ready;
  ucfc_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/ucfc_frame_store.sv
// Frame byte store and saturating burst byte counter.
module ucfc_frame_store #(
  parameter int unsigned BufferBytes = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ucfc_pkg::store_ctrl_t               ctrl_i,
  input  logic [ucfc_pkg::ByteW-1:0]          rx_byte_i,
  output ucfc_pkg::frame_t                    frame_o,
  output logic [ucfc_pkg::CountW-1:0]         count_o
);

  localparam logic [ucfc_pkg::CountW-1:0] CountLimit = ucfc_pkg::CountW'(BufferBytes);
  localparam logic [ucfc_pkg::CountW-1:0] FrameLimit =
    ucfc_pkg::CountW'(ucfc_pkg::FrameBytes);

  ucfc_pkg::frame_t                 frame_q, frame_d;
  logic [ucfc_pkg::CountW-1:0]      count_q, count_d;

  always_comb begin
    frame_d = frame_q;
    count_d = count_q;
    if (ctrl_i.close_burst) begin
      frame_d = '0;
      count_d = '0;
    end else if (ctrl_i.store_byte) begin
      if (count_q < FrameLimit) begin
        frame_d[count_q[ucfc_pkg::CountIdxW-1:0]] = rx_byte_i;
      end
      if (count_q < CountLimit) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      count_q <= '0;
    end else begin
      frame_q <= frame_d;
      count_q <= count_d;
    end
  end

  assign frame_o = frame_q;
  assign count_o = count_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CountLimit)
    else $error("Burst byte count exceeds its limit.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.close_burst |=> (count_q == '0) && (frame_q == '0))
    else $error("Store not cleared after a closed burst.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.store_byte && !ctrl_i.close_burst && count_q < CountLimit) |=>
    count_q == $past(count_q) + 1'b1)
    else $error("Burst byte count did not advance.");
`endif

endmodule

FILE: hw/rtl/ucfc_frame_eval.sv
// Frame checks, field extraction and decimal conversion for one burst.
module ucfc_frame_eval (
  input  ucfc_pkg::frame_t             frame_i,
  input  logic [ucfc_pkg::CountW-1:0]  count_i,
  input  ucfc_pkg::cfg_t               cfg_i,
  output ucfc_pkg::res_t               res_o
);

  logic [ucfc_pkg::ByteW-1:0] sum;
  logic [ucfc_pkg::ByteW-1:0] func;
  logic                       known_func;
  logic [15:0]                dec;
  ucfc_pkg::status_e          status;

  assign func = frame_i[1];

  always_comb begin
    sum = frame_i[0] + frame_i[1] + frame_i[2] + frame_i[3] + frame_i[4] + frame_i[5]
        + frame_i[6] + frame_i[7];
    known_func = func inside {ucfc_pkg::FuncDecimal, ucfc_pkg::FuncE4, ucfc_pkg::FuncD3,
                              ucfc_pkg::FuncC2, ucfc_pkg::FuncB1, ucfc_pkg::FuncA0};
    if (frame_i[0] != cfg_i.header_byte || frame_i[8] != cfg_i.tail_byte) begin
      status = ucfc_pkg::ST_BAD_FRAME;
    end else if (sum != '0) begin
      status = ucfc_pkg::ST_BAD_SUM;
    end else if (!known_func) begin
      status = ucfc_pkg::ST_BAD_FUNC;
    end else begin
      status = ucfc_pkg::ST_OK;
    end
    dec = 16'(16'(frame_i[3]) * 16'd1000 + 16'(frame_i[4]) * 16'd100
        + 16'(frame_i[5]) * 16'd10 + 16'(frame_i[6]) - ucfc_pkg::DecBias);
  end

  always_comb begin
    res_o.status        = status;
    res_o.function_code = func;
    res_o.length_byte   = frame_i[2];
    res_o.data_0        = frame_i[3];
    res_o.data_1        = frame_i[4];
    res_o.data_2        = frame_i[5];
    res_o.data_3        = frame_i[6];
    res_o.decimal_value =
      (status == ucfc_pkg::ST_OK && func == ucfc_pkg::FuncDecimal) ? dec : '0;
    res_o.burst_length  = count_i;
  end

endmodule

FILE: hw/rtl/ucfc_out_buf.sv
// Two-entry result register that decouples the result channel from the request side.
module ucfc_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ucfc_pkg::res_t res_i,
  output logic           ready_o,
  ucfc_res_if.source     res_o
);

  ucfc_pkg::res_t main_q, skid_q;
  logic           main_valid_q, skid_valid_q;
  logic           pop;

  assign pop     = main_valid_q && res_o.ready;
  assign ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!main_valid_q || pop) begin
        if (skid_valid_q) begin
          main_valid_q <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          main_valid_q <= push_i;
        end
      end else if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_valid_q || pop) begin
      main_q <= skid_valid_q ? skid_q : res_i;
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  assign res_o.valid = main_valid_q;
  assign res_o.data  = main_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> main_valid_q)
    else $error("Skid entry holds a result while the main entry is empty.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !skid_valid_q)
    else $error("Result pushed while both entries are full.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && skid_valid_q) |=> (main_valid_q && !skid_valid_q))
    else $error("Skid entry did not move up after a pop.");
`endif

endmodule

FILE: hw/rtl/uart_command_frame_checker.sv
// Top level of the UART command frame checker.
//
//   Channel  Direction  Payload                          Handshake
//   req_i    in         req_type, rx_byte                valid/ready
//   res_o    out        status, fields, decimal, length  valid/ready
//   cfg      in         cfg_idx_i, cfg_wdata_i           cfg_we_i, no wait
//
// One request is taken per cycle while req_i is ready; a timeout request's result is
// read straight from the registered frame store and registered into the result buffer.
// A two-entry result buffer keeps req_i ready while one result waits; req_i
// stalls only when both entries are full.
// Reset clears the store, the byte count and the result buffer, and loads the
// default header and tail bytes.
module uart_command_frame_checker #(
  parameter int unsigned BUFFER_BYTES = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ucfc_req_if.sink                       req_i,
  ucfc_res_if.source                     res_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [ucfc_pkg::ByteW-1:0]     cfg_wdata_i
);

  ucfc_pkg::cfg_t             cfg_q;
  ucfc_pkg::store_ctrl_t      store_ctrl;
  ucfc_pkg::frame_t           frame;
  logic [ucfc_pkg::CountW-1:0] count;
  ucfc_pkg::res_t             res;
  logic                       buf_ready;
  logic                       accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte <= ucfc_pkg::HeaderReset;
      cfg_q.tail_byte   <= ucfc_pkg::TailReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ucfc_pkg::CfgHeader: cfg_q.header_byte <= cfg_wdata_i;
        ucfc_pkg::CfgTail:   cfg_q.tail_byte   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign req_i.ready            = buf_ready;
  assign accept                 = req_i.valid && buf_ready;
  assign store_ctrl.store_byte  = accept && (req_i.data.req_type == ucfc_pkg::ReqByte);
  assign store_ctrl.close_burst = accept && (req_i.data.req_type == ucfc_pkg::ReqTimeout);

  ucfc_frame_store #(
    .BufferBytes (BUFFER_BYTES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (store_ctrl),
    .rx_byte_i (req_i.data.rx_byte),
    .frame_o   (frame),
    .count_o   (count)
  );

  ucfc_frame_eval u_eval (
    .frame_i (frame),
    .count_i (count),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  ucfc_out_buf u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (store_ctrl.close_burst),
    .res_i   (res),
    .ready_o (buf_ready),
    .res_o   (res_o)
  );

endmodule

FILE: sim/ucfc_tb_pkg.sv
// Frame tracker class that predicts and checks the reports of the UART command frame checker.
package ucfc_tb_pkg;
  import ucfc_pkg::*;

  typedef logic [ByteW-1:0] byte_q_t[$];

  function automatic bit known_code(logic [ByteW-1:0] code);
    return code inside {FuncDecimal, FuncE4, FuncD3, FuncC2, FuncB1, FuncA0};
  endfunction

  class frame_tracker;
    int unsigned       count_limit;
    logic [ByteW-1:0]  header_q;
    logic [ByteW-1:0]  tail_q;
    logic [ByteW-1:0]  frame_q[FrameBytes];
    logic [CountW-1:0] count_q;
    res_t              expected_reports[$];
    int unsigned       mismatch_count;

    function new(int unsigned limit);
      count_limit    = limit;
      header_q       = HeaderReset;
      tail_q         = TailReset;
      mismatch_count = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      foreach (frame_q[i]) frame_q[i] = '0;
      count_q = '0;
    endfunction

    function void set_register(logic idx, logic [ByteW-1:0] value);
      if (idx == CfgHeader) begin
        header_q = value;
      end else begin
        tail_q = value;
      end
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction

    function void note_request(req_t r);
      res_t             report;
      logic [ByteW-1:0] sum;
      logic [31:0]      acc;
      if (r.req_type == ReqByte) begin
        if (count_q < FrameBytes) frame_q[count_q] = r.rx_byte;
        if (count_q < count_limit) count_q++;
        return;
      end
      sum = '0;
      for (int i = 0; i < 7; i++) sum += frame_q[i];
      if (frame_q[0] != header_q || frame_q[8] != tail_q) begin
        report.status = ST_BAD_FRAME;
      end else if (8'(frame_q[7] + sum) != 8'h00) begin
        report.status = ST_BAD_SUM;
      end else if (!known_code(frame_q[1])) begin
        report.status = ST_BAD_FUNC;
      end else begin
        report.status = ST_OK;
      end
      report.decimal_value = '0;
      if (report.status == ST_OK && frame_q[1] == FuncDecimal) begin
        acc = (32'(frame_q[3]) - 32'd48) * 32'd1000 + (32'(frame_q[4]) - 32'd48) * 32'd100
            + (32'(frame_q[5]) - 32'd48) * 32'd10 + (32'(frame_q[6]) - 32'd48);
        report.decimal_value = acc[15:0];
      end
      report.function_code = frame_q[1];
      report.length_byte   = frame_q[2];
      report.data_0        = frame_q[3];
      report.data_1        = frame_q[4];
      report.data_2        = frame_q[5];
      report.data_3        = frame_q[6];
      report.burst_length  = count_q;
      expected_reports.push_back(report);
      clear_frame();
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        mismatch_count++;
      end
    endfunction

    function void check_result(res_t act);
      res_t exp;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual %p", $time, act);
        mismatch_count++;
        return;
      end
      exp = expected_reports.pop_front();
      compare_field("status", 16'(exp.status), 16'(act.status));
      compare_field("function_code", 16'(exp.function_code), 16'(act.function_code));
      compare_field("length_byte", 16'(exp.length_byte), 16'(act.length_byte));
      compare_field("data_0", 16'(exp.data_0), 16'(act.data_0));
      compare_field("data_1", 16'(exp.data_1), 16'(act.data_1));
      compare_field("data_2", 16'(exp.data_2), 16'(act.data_2));
      compare_field("data_3", 16'(exp.data_3), 16'(act.data_3));
      compare_field("decimal_value", exp.decimal_value, act.decimal_value);
      compare_field("burst_length", 16'(exp.burst_length), 16'(act.burst_length));
    endfunction
  endclass

endpackage

FILE: sim/uart_command_frame_checker_tb.sv
// Testbench that drives random and directed byte bursts into the frame checker and checks reports.
module uart_command_frame_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ucfc_pkg::*;
  import ucfc_tb_pkg::*;

  localparam int unsigned BufferBytes = 128;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseItems  = 140;

  localparam logic [ByteW-1:0] KnownCodes[6] = '{FuncDecimal, FuncE4, FuncD3,
                                                 FuncC2, FuncB1, FuncA0};

  typedef enum int {
    BURST_GOOD,
    BURST_BAD_SUM,
    BURST_BAD_FUNC,
    BURST_BAD_EDGE,
    BURST_SHORT,
    BURST_LONG,
    BURST_NOISE
  } burst_kind_e;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic             cfg_idx;
  logic [ByteW-1:0] cfg_wdata;

  frame_tracker tracker;
  bit           calm;
  bit           hold_request;
  int unsigned  cycle_count;
  int unsigned  stall_left;
  int unsigned  items_sent;

  ucfc_req_if req_ch ();
  ucfc_res_if res_ch ();

  uart_command_frame_checker #(
    .BUFFER_BYTES(BufferBytes)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("uart_command_frame_checker test failed");
    $finish;
  end

  initial begin
    logic next_ready;
    res_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_ch.valid && res_ch.ready) tracker.check_result(res_ch.data);
      if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HoldCycles - 1;
        next_ready   = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 18);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      res_ch.ready <= next_ready;
    end
  end

  function automatic logic [ByteW-1:0] checksum_of(byte_q_t b);
    logic [ByteW-1:0] s;
    s = '0;
    for (int i = 0; i < 7; i++) s += b[i];
    return 8'(8'h00 - s);
  endfunction

  task automatic send_request(logic kind, logic [ByteW-1:0] value);
    req_t        r;
    int unsigned gap;
    r.req_type = kind;
    r.rx_byte  = value;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    tracker.note_request(r);
    items_sent++;
  endtask

  task automatic send_burst(byte_q_t bytes);
    foreach (bytes[i]) send_request(ReqByte, bytes[i]);
    send_request(ReqTimeout, 8'($urandom));
  endtask

  task automatic wait_quiet();
    req_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_registers(logic [ByteW-1:0] header, logic [ByteW-1:0] tail);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgHeader;
    cfg_wdata <= header;
    @(posedge clk_i);
    tracker.set_register(CfgHeader, header);
    cfg_idx   <= CfgTail;
    cfg_wdata <= tail;
    @(posedge clk_i);
    tracker.set_register(CfgTail, tail);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_burst(bit saturate);
    byte_q_t     f;
    burst_kind_e kind;
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (saturate || pick < 40) kind = BURST_GOOD;
    else if (pick < 52) kind = BURST_BAD_SUM;
    else if (pick < 62) kind = BURST_BAD_FUNC;
    else if (pick < 72) kind = BURST_BAD_EDGE;
    else if (pick < 82) kind = BURST_SHORT;
    else if (pick < 92) kind = BURST_LONG;
    else kind = BURST_NOISE;

    f.push_back(tracker.header_q);
    f.push_back(KnownCodes[$urandom_range(0, 5)]);
    f.push_back(8'($urandom));
    repeat (4) begin
      if (f[1] == FuncDecimal && $urandom_range(0, 3) != 0) begin
        f.push_back(8'(48 + $urandom_range(0, 9)));
      end else begin
        f.push_back(8'($urandom));
      end
    end
    if (kind == BURST_BAD_FUNC) begin
      do f[1] = 8'($urandom); while (known_code(f[1]));
    end
    if (kind == BURST_BAD_EDGE && $urandom_range(0, 1) == 0) begin
      f[0] ^= 8'($urandom_range(1, 255));
    end
    f.push_back(checksum_of(f));
    f.push_back(tracker.tail_q);
    if (kind == BURST_BAD_EDGE) begin
      if (f[0] == tracker.header_q || $urandom_range(0, 1) == 0) begin
        f[8] ^= 8'($urandom_range(1, 255));
      end
      if ($urandom_range(0, 1) == 0) f[7] = 8'h00;
    end
    if (kind == BURST_BAD_SUM) f[7] ^= 8'($urandom_range(1, 255));

    case (kind)
      BURST_SHORT: begin
        n = $urandom_range(0, 8);
        while (f.size() > n) void'(f.pop_back());
      end
      BURST_LONG: begin
        repeat ($urandom_range(1, 12)) f.push_back(8'($urandom));
      end
      BURST_NOISE: begin
        f.delete();
        repeat ($urandom_range(0, 20)) f.push_back(8'($urandom));
      end
      default: begin
        if (saturate) repeat ($urandom_range(120, 140)) f.push_back(8'($urandom));
      end
    endcase
    send_burst(f);
  endtask

  initial begin
    byte_q_t     bytes;
    int unsigned start;
    tracker      = new(BufferBytes);
    calm         = 1'b0;
    hold_request = 1'b0;
    items_sent   = 0;
    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CfgHeader;
    cfg_wdata    <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A good decimal request, an empty burst, a short burst and a zero-checksum frame
    // with a bad tail.
    bytes = '{8'h30, 8'hF5, 8'h04, 8'h31, 8'h32, 8'h33, 8'h34};
    bytes.push_back(checksum_of(bytes));
    bytes.push_back(8'h36);
    send_burst(bytes);
    bytes.delete();
    send_burst(bytes);
    bytes = '{8'h00, 8'hFF, 8'h80};
    send_burst(bytes);
    bytes = '{8'h30, 8'hD3, 8'h04, 8'h00, 8'h00, 8'h00, 8'hF9, 8'h00, 8'h00};
    send_burst(bytes);

    for (int p = 0; p < 5; p++) begin
      wait_quiet();
      case (p)
        0: write_registers(8'h00, 8'hFF);
        1: write_registers(8'hFF, 8'h00);
        2: begin
          write_registers(8'($urandom), 8'($urandom));
          hold_request = 1'b1;
        end
        3: write_registers(8'($urandom), 8'($urandom));
        default: begin
          write_registers(HeaderReset, TailReset);
          calm = 1'b1;
        end
      endcase
      start = items_sent;
      if (p == 1 || p == 3) send_random_burst(1'b1);
      while (items_sent - start < PhaseItems) send_random_burst(1'b0);
    end

    wait_quiet();
    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("uart_command_frame_checker test passed");
    end else begin
      $display("uart_command_frame_checker test failed");
    end
    $finish;
  end

endmodule
